@@ rtl/core/itp_pkg.sv @@
package itp_pkg;

    localparam int SYM_W       = 8;
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] CH_ADD = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_FLUSH
    } t_back_state;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_op;
        t_op              op;
        logic             last;
    } t_item;

    function automatic logic [SYM_W-1:0] op_char(input t_op op);
        logic [SYM_W-1:0] ch;
        case (op)
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            default: ch = CH_DIV;
        endcase
        return ch;
    endfunction

    // Multiplication and division bind tighter than addition and subtraction.
    function automatic logic op_is_high(input t_op op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

@@ rtl/core/itp_ifs.sv @@
interface itp_in_if;
    logic                       valid;
    logic                       ready;
    logic [itp_pkg::SYM_W-1:0]  symbol;
    logic                       end_of_expr;

    modport source (output valid, symbol, end_of_expr, input ready);
    modport sink   (input valid, symbol, end_of_expr, output ready);
endinterface

interface itp_out_if;
    logic                       valid;
    logic                       ready;
    logic [itp_pkg::SYM_W-1:0]  out_symbol;
    logic                       out_last;
    logic                       overflow_seen;

    modport source (output valid, out_symbol, out_last, overflow_seen, input ready);
    modport sink   (input valid, out_symbol, out_last, overflow_seen, output ready);
endinterface

@@ rtl/core/itp_front.sv @@
module itp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itp_in_if.sink        i_in,
    output itp_pkg::t_item o_item,
    output logic          o_item_valid,
    input  logic          i_item_ready
);
    import itp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_in.ready   = !r_valid || i_item_ready;
    assign o_item       = r_item;
    assign o_item_valid = r_valid;

    always_comb begin
        n_item.symbol = i_in.symbol;
        n_item.last   = i_in.end_of_expr;
        n_item.is_op  = 1'b1;
        case (i_in.symbol)
            CH_ADD:  n_item.op = OP_ADD;
            CH_SUB:  n_item.op = OP_SUB;
            CH_MUL:  n_item.op = OP_MUL;
            CH_DIV:  n_item.op = OP_DIV;
            default: begin
                n_item.op    = OP_ADD;
                n_item.is_op = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/core/itp_queue.sv @@
module itp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itp_pkg::t_item i_push_item,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    output itp_pkg::t_item o_pop_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready
);
    import itp_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (w_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

@@ rtl/core/itp_back.sv @@
module itp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itp_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    itp_out_if.source      o_out
);
    import itp_pkg::*;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    t_op              r_stack [STACK_DEPTH];
    t_op              r_top;
    t_op              r_op;
    logic             r_last;

    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_symbol;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             w_slot_free;
    logic [CNT_W-1:0] w_cnt_dec;
    logic [CNT_W-1:0] w_cnt_dec2;
    t_op              w_top;
    logic             w_pop_cond;
    logic             w_full;

    logic             w_emit;
    logic [SYM_W-1:0] w_emit_sym;
    logic             w_emit_last;
    logic             w_pop;
    logic             w_push;
    logic             w_latch;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_cnt_dec   = r_count - CNT_W'(1);
    assign w_cnt_dec2  = r_count - CNT_W'(2);
    assign w_top       = r_top;
    assign w_full      = (r_count >= CNT_W'(STACK_DEPTH));
    // A stacked operator leaves when its precedence is not below the incoming one.
    assign w_pop_cond  = (r_count != '0) && (!op_is_high(r_op) || op_is_high(w_top));

    assign o_out.valid         = r_out_valid;
    assign o_out.out_symbol    = r_out_symbol;
    assign o_out.out_last      = r_out_last;
    assign o_out.overflow_seen = r_out_ovf;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.is_op) begin
                        n_state = BK_POP;
                    end else if (w_slot_free && i_item.last && (r_count != '0)) begin
                        n_state = BK_FLUSH;
                    end
                end
            end
            BK_POP: begin
                if (!w_pop_cond) begin
                    n_state = r_last ? BK_FLUSH : BK_IDLE;
                end
            end
            BK_FLUSH: begin
                if (r_count == '0) begin
                    n_state = BK_IDLE;
                end else if (w_slot_free && (r_count == CNT_W'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = 1'b0;
        w_emit       = 1'b0;
        w_emit_sym   = i_item.symbol;
        w_emit_last  = 1'b0;
        w_pop        = 1'b0;
        w_push       = 1'b0;
        w_latch      = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.is_op) begin
                        o_item_ready = 1'b1;
                        w_latch      = 1'b1;
                    end else if (w_slot_free) begin
                        o_item_ready = 1'b1;
                        w_emit       = 1'b1;
                        w_emit_last  = i_item.last && (r_count == '0);
                    end
                end
            end
            BK_POP: begin
                if (w_pop_cond) begin
                    if (w_slot_free) begin
                        w_emit     = 1'b1;
                        w_emit_sym = op_char(w_top);
                        w_pop      = 1'b1;
                    end
                end else begin
                    w_push = 1'b1;
                end
            end
            BK_FLUSH: begin
                if ((r_count != '0) && w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_sym  = op_char(w_top);
                    w_emit_last = (r_count == CNT_W'(1));
                    w_pop       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_count <= w_cnt_dec;
            end else if (w_push && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_push && w_full) begin
                r_ovf <= 1'b1;
            end
            if (w_slot_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // The flag can only change on a push, and a push that finds the stack full
    // never follows a pop of the same transaction, so the value sent is final.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_symbol <= w_emit_sym;
            r_out_last   <= w_emit_last;
            r_out_ovf    <= r_ovf;
        end
        if (w_latch) begin
            r_op   <= i_item.op;
            r_last <= i_item.last;
        end
        if (w_push && !w_full) begin
            r_stack[r_count[PTR_W-1:0]] <= r_op;
        end
    end

    // The top of the stack is kept in a register; a pop reads the entry below it.
    always_ff @(posedge i_clk) begin
        if (w_push && !w_full) begin
            r_top <= r_op;
        end else if (w_pop) begin
            r_top <= r_stack[w_cnt_dec2[PTR_W-1:0]];
        end
    end

endmodule

@@ rtl/core/infix_to_postfix_converter.sv @@
// Infix to postfix converter, shunting-yard style, for + - * / without
// parentheses. One expression character is taken per input transaction and the
// postfix characters leave one per output transaction; out_last marks the final
// character of an expression and overflow_seen reports a dropped push onto the
// full operator stack. The input side registers and queues up to three
// characters, so it keeps accepting while the stack engine is busy. The stack
// engine decides the rate: an operand is passed straight on, an operator is
// taken in, pops each stacked operator that binds at least as tightly and is
// then pushed, and the end of an expression pops every operator left on the
// stack. The engine takes the next character only once it is done with the
// current one. A stalled output holds the engine but not the input queue.
module infix_to_postfix_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itp_in_if.sink     i_in,
    itp_out_if.source  o_out
);
    import itp_pkg::*;

    t_item w_front_item;
    logic  w_front_valid;
    logic  w_front_ready;
    t_item w_queue_item;
    logic  w_queue_valid;
    logic  w_queue_ready;

    itp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_front_item),
        .o_item_valid (w_front_valid),
        .i_item_ready (w_front_ready)
    );

    itp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (w_front_item),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .o_pop_item   (w_queue_item),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_queue_ready)
    );

    itp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_queue_item),
        .i_item_valid (w_queue_valid),
        .o_item_ready (w_queue_ready),
        .o_out        (o_out)
    );

endmodule

@@ rtl/core/itp_checker.sv @@
module itp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_end,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [itp_pkg::SYM_W-1:0] i_out_symbol,
    input logic                      i_out_last,
    input logic                      i_out_ovf
);
    import itp_pkg::*;

    logic [2:0] r_ends;
    logic       r_ovf_shown;
    logic       w_in_end;
    logic       w_out_end;

    assign w_in_end  = i_in_valid && i_in_ready && i_in_end;
    assign w_out_end = i_out_valid && i_out_ready && i_out_last;

    // Expressions taken in but whose final character has not yet left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ends      <= '0;
            r_ovf_shown <= 1'b0;
        end else begin
            if (w_in_end && !w_out_end) begin
                r_ends <= r_ends + 3'd1;
            end else if (w_out_end && !w_in_end) begin
                r_ends <= r_ends - 3'd1;
            end
            if (i_out_valid && i_out_ready && i_out_ovf) begin
                r_ovf_shown <= 1'b1;
            end
        end
    end

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_symbol)
            && $stable(i_out_last) && $stable(i_out_ovf))
        else $error("stalled output transaction changed");

    a_last_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_end |-> (r_ends != 3'd0))
        else $error("end of expression sent with no expression ended at the input");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_ovf_shown |-> i_out_ovf)
        else $error("overflow flag cleared after it had been reported");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_end     (i_in.end_of_expr),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.out_symbol),
    .i_out_last   (o_out.out_last),
    .i_out_ovf    (o_out.overflow_seen)
);

@@ dv/infix_to_postfix_converter_tb.sv @@
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    localparam int GAP_MAX       = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 270;

    localparam logic [SYM_W-1:0] OP_CHARS [4] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             overflow;
    } t_postfix_char;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    itp_in_if  in_if ();
    itp_out_if out_if ();

    infix_to_postfix_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit decode_operator(input logic [SYM_W-1:0] sym, output t_op code);
        code = OP_ADD;
        case (sym)
            CH_ADD: code = OP_ADD;
            CH_SUB: code = OP_SUB;
            CH_MUL: code = OP_MUL;
            CH_DIV: code = OP_DIV;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic int binding(input t_op code);
        return (code == OP_MUL || code == OP_DIV) ? 3 : 2;
    endfunction

    class postfix_scoreboard;
        t_op           op_stack [STACK_DEPTH];
        int            depth;
        bit            overflow;
        t_postfix_char postfix_due [$];
        int            mismatches;

        function new();
            depth      = 0;
            overflow   = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return postfix_due.size();
        endfunction

        // Works out the postfix characters that one accepted input transaction releases.
        function void note_symbol(input logic [SYM_W-1:0] sym, input logic eoe);
            logic [SYM_W-1:0] emitted [$];
            t_op              code;
            t_postfix_char    pc;
            if (decode_operator(sym, code)) begin
                while (depth > 0 && binding(op_stack[depth-1]) >= binding(code)) begin
                    depth--;
                    emitted.push_back(OP_CHARS[op_stack[depth]]);
                end
                if (depth < STACK_DEPTH) begin
                    op_stack[depth] = code;
                    depth++;
                end else begin
                    overflow = 1'b1;
                end
            end else begin
                emitted.push_back(sym);
            end
            if (eoe) begin
                while (depth > 0) begin
                    depth--;
                    emitted.push_back(OP_CHARS[op_stack[depth]]);
                end
            end
            foreach (emitted[i]) begin
                pc.symbol   = emitted[i];
                pc.last     = eoe && (i == emitted.size() - 1);
                pc.overflow = overflow;
                postfix_due.push_back(pc);
            end
        endfunction

        function void check_result(input logic [SYM_W-1:0] sym, input logic last,
                                   input logic ovf);
            t_postfix_char want;
            if (postfix_due.size() == 0) begin
                $display("%0t: unexpected output transaction, symbol %02h last %0b overflow %0b",
                         $time, sym, last, ovf);
                mismatches++;
                return;
            end
            want = postfix_due.pop_front();
            if (sym !== want.symbol) begin
                $display("%0t: out_symbol expected %02h, got %02h", $time, want.symbol, sym);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: out_last expected %0b, got %0b", $time, want.last, last);
                mismatches++;
            end
            if (ovf !== want.overflow) begin
                $display("%0t: overflow_seen expected %0b, got %0b",
                         $time, want.overflow, ovf);
                mismatches++;
            end
        endfunction
    endclass

    postfix_scoreboard sb;
    bit burst_mode    = 1'b0;
    bit sink_hold_req = 1'b0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [SYM_W-1:0] any_operand();
        logic [SYM_W-1:0] sym;
        t_op              code;
        do begin
            sym = SYM_W'($urandom_range(1, 255));
        end while (decode_operator(sym, code));
        return sym;
    endfunction

    function automatic logic [SYM_W-1:0] any_operator();
        return OP_CHARS[$urandom_range(0, 3)];
    endfunction

    // The task lowers valid only for a gap before the transaction, so a back-to-back transaction keeps it high.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic eoe);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.symbol      <= sym;
        in_if.end_of_expr <= eoe;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_symbol(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_expression(input int operands);
        for (int i = 0; i < operands; i++) begin
            if (i > 0) begin
                send_symbol(any_operator(), 1'b0);
            end
            send_symbol(any_operand(), i == operands - 1);
        end
    endtask

    // Operators back to back, stray end marks and end marks on operators.
    task automatic send_noise(input int count);
        logic [SYM_W-1:0] sym;
        for (int i = 0; i < count; i++) begin
            sym = $urandom_range(0, 1) ? any_operator() : SYM_W'($urandom_range(1, 255));
            send_symbol(sym, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : symbol_source
        int target;
        sb = new();
        in_if.valid       <= 1'b0;
        in_if.symbol      <= '0;
        in_if.end_of_expr <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part.
        send_text("a");
        send_symbol(8'hFF, 1'b0);
        send_symbol(CH_ADD, 1'b0);
        send_symbol(8'h01, 1'b1);
        send_text("a-b*c/d+e");
        // A zero symbol is an ordinary operand.
        send_symbol(8'h00, 1'b0);
        send_symbol(CH_MUL, 1'b0);
        send_symbol(8'h80, 1'b1);
        send_text("x+");
        send_text("/y");
        send_text("*");
        drain_results();

        // Random part.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_mode = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_noise($urandom_range(1, 8));
            end else begin
                send_expression($urandom_range(1, 6));
            end
            if (items_sent >= target - RANDOM_ITEMS / 2 && !sink_hold_req) begin
                // Fill the block while the output side holds off, then let it drain.
                sink_hold_req = 1'b1;
                burst_mode    = 1'b1;
                for (int j = 0; j < 8; j++) begin
                    send_expression($urandom_range(2, 4));
                end
                burst_mode = 1'b0;
                drain_results();
            end
        end
        drain_results();

        if (sb.mismatches == 0) begin
            $display("infix_to_postfix_converter: match");
        end else begin
            $display("infix_to_postfix_converter: mismatch");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = draw_gap();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_symbol(in_if.symbol, in_if.end_of_expr);
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.out_symbol, out_if.out_last, out_if.overflow_seen);
                moved = 1'b1;
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("infix_to_postfix_converter: mismatch");
                $finish;
            end
        end
    end

endmodule
